FILE: rtl/isi_pkg.sv
// Shared types and codes of the image sample interpolator.
package isi_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_METHOD = 2'd2;

	// Interpolation methods
	localparam logic [1:0] METH_NEAREST  = 2'd0;
	localparam logic [1:0] METH_BILINEAR = 2'd1;
	localparam logic [1:0] METH_BICUBIC  = 2'd2;

	// Item kinds
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Fixed field widths
	localparam int COORD_W = 17;
	localparam int POS_W   = 7;
	localparam int CH_W    = 8;
	localparam int CFG_W   = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_CUBE,
		ST_WEIGHT,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       write;
		logic       load;
		logic       square;
		logic       cube;
		logic       weight;
		logic       tap_valid;
		logic [1:0] tap_i;
		logic [1:0] tap_j;
		logic       finish;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic busy;
	} stat_t;

endpackage

FILE: rtl/isi_in_if.sv
// Input channel: write and sample words.
interface isi_in_if;
	logic                                        valid;
	logic                                        ready;
	logic                                        action;
	logic [isi_pkg::POS_W-1:0]                   write_col;
	logic [isi_pkg::POS_W-1:0]                   write_row;
	logic [isi_pkg::CH_W-1:0]                    write_red;
	logic [isi_pkg::CH_W-1:0]                    write_green;
	logic [isi_pkg::CH_W-1:0]                    write_blue;
	logic [isi_pkg::CH_W-1:0]                    write_alpha;
	logic signed [isi_pkg::COORD_W-1:0]          sample_x;
	logic signed [isi_pkg::COORD_W-1:0]          sample_y;

	modport source (output valid, action, write_col, write_row, write_red, write_green,
		write_blue, write_alpha, sample_x, sample_y, input ready);
	modport sink (input valid, action, write_col, write_row, write_red, write_green,
		write_blue, write_alpha, sample_x, sample_y, output ready);
endinterface

FILE: rtl/isi_out_if.sv
// Output channel: interpolated RGBA words.
interface isi_out_if;
	logic                     valid;
	logic                     ready;
	logic [isi_pkg::CH_W-1:0] out_red;
	logic [isi_pkg::CH_W-1:0] out_green;
	logic [isi_pkg::CH_W-1:0] out_blue;
	logic [isi_pkg::CH_W-1:0] out_alpha;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

FILE: rtl/image_sample_interpolator.sv
// Top level of the image sample interpolator: config registers, controller, datapath.
//
//   channel  dir  handshake       word
//   din      in   valid/ready     pixel write or sample coordinate
//   dout     out  valid/ready     RGBA result of one sample
//   cfg      in   cfg_we          width, height, method
//
// A pixel write is taken in idle. A sample runs the weight setup steps (square,
// cube, weight), one memory read per tap (1 nearest, 4 bilinear, 16 bicubic), a
// drain until the multiply-accumulate pipeline is empty, a round step and a return
// to idle to take the next word; the single memory port sets the tap rate.
// arst_n clears control state; pixel memory content is undefined until written.
// The next item is taken while a result waits in the output register; a sample
// holds in its last step until that register is free.
module image_sample_interpolator #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int FRAC_BITS  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	isi_in_if.sink                        din,
	isi_out_if.source                     dout,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [isi_pkg::CFG_W-1:0]     cfg_data
);

	logic [isi_pkg::CFG_W-1:0] width_q, height_q;
	logic [1:0]                method_q;
	isi_pkg::cmd_t             cmd;
	isi_pkg::stat_t            stat;
	logic [4*isi_pkg::CH_W-1:0] result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= isi_pkg::CFG_W'(128);
			height_q <= isi_pkg::CFG_W'(128);
			method_q <= isi_pkg::METH_BILINEAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				isi_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				isi_pkg::CFG_HEIGHT: height_q <= cfg_data;
				isi_pkg::CFG_METHOD: method_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	isi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_action (din.action),
		.method    (method_q),
		.out_ready (dout.ready),
		.stat      (stat),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.cmd       (cmd)
	);

	isi_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.image_width  (width_q),
		.image_height (height_q),
		.method       (method_q),
		.write_col    (din.write_col),
		.write_row    (din.write_row),
		.write_pixel  ({din.write_alpha, din.write_blue, din.write_green, din.write_red}),
		.sample_x     (din.sample_x),
		.sample_y     (din.sample_y),
		.stat         (stat),
		.result       (result)
	);

	// Drive the output word
	assign dout.out_red   = result[7:0];
	assign dout.out_green = result[15:8];
	assign dout.out_blue  = result[23:16];
	assign dout.out_alpha = result[31:24];

endmodule

FILE: rtl/isi_ctrl.sv
// Sequencer for pixel writes and sample passes over the tap window.
module isi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_action,
	input  logic [1:0]         method,
	input  logic               out_ready,
	input  isi_pkg::stat_t     stat,
	output logic               in_ready,
	output logic               out_valid,
	output isi_pkg::cmd_t      cmd
);

	isi_pkg::state_t state_q, state_d;
	logic [1:0] i_q, j_q, i_d, j_d;
	logic [1:0] lo, hi;
	logic       out_valid_q, out_valid_d;

	// Tap window bounds per method
	always_comb begin
		unique case (method)
			isi_pkg::METH_BICUBIC: begin
				lo = 2'd0;
				hi = 2'd3;
			end
			isi_pkg::METH_BILINEAR: begin
				lo = 2'd1;
				hi = 2'd2;
			end
			default: begin
				lo = 2'd1;
				hi = 2'd1;
			end
		endcase
	end

	// State, tap counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= isi_pkg::ST_IDLE;
			i_q         <= 2'd0;
			j_q         <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			i_q         <= i_d;
			j_q         <= j_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		i_d         = i_q;
		j_d         = j_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		cmd.tap_i   = i_q;
		cmd.tap_j   = j_q;
		in_ready    = 1'b0;
		unique case (state_q)
			isi_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_action == isi_pkg::ACT_WRITE) begin
						cmd.write = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = isi_pkg::ST_SQUARE;
					end
				end
			end
			isi_pkg::ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = isi_pkg::ST_CUBE;
			end
			isi_pkg::ST_CUBE: begin
				cmd.cube = 1'b1;
				state_d  = isi_pkg::ST_WEIGHT;
			end
			isi_pkg::ST_WEIGHT: begin
				cmd.weight = 1'b1;
				i_d        = lo;
				j_d        = lo;
				state_d    = isi_pkg::ST_READ;
			end
			isi_pkg::ST_READ: begin
				cmd.tap_valid = 1'b1;
				if (i_q == hi) begin
					i_d = lo;
					if (j_q == hi) begin
						state_d = isi_pkg::ST_DRAIN;
					end else begin
						j_d = j_q + 2'd1;
					end
				end else begin
					i_d = i_q + 2'd1;
				end
			end
			isi_pkg::ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = isi_pkg::ST_FINISH;
				end
			end
			isi_pkg::ST_FINISH: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = isi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = isi_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/isi_datapath.sv
// Pixel memory, weight generation, multiply-accumulate lanes and rounding.
module isi_datapath #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  isi_pkg::cmd_t                       cmd,
	input  logic [isi_pkg::CFG_W-1:0]           image_width,
	input  logic [isi_pkg::CFG_W-1:0]           image_height,
	input  logic [1:0]                          method,
	input  logic [isi_pkg::POS_W-1:0]           write_col,
	input  logic [isi_pkg::POS_W-1:0]           write_row,
	input  logic [4*isi_pkg::CH_W-1:0]          write_pixel,
	input  logic signed [isi_pkg::COORD_W-1:0]  sample_x,
	input  logic signed [isi_pkg::COORD_W-1:0]  sample_y,
	output isi_pkg::stat_t                      stat,
	output logic [4*isi_pkg::CH_W-1:0]          result
);

	localparam int FB    = FRAC_BITS;
	localparam int WW    = 3*FB + 4;
	localparam int LW    = (WW + 1) / 2;
	localparam int HW    = WW - LW;
	localparam int PW    = WW + 9;
	localparam int MLW   = PW + LW + 1;
	localparam int MHW   = PW + HW;
	localparam int AW    = 6*FB + 18;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADW   = $clog2(DEPTH);
	localparam int CW    = 19;
	localparam int CB    = $clog2(MAX_WIDTH);
	localparam int RB    = $clog2(MAX_HEIGHT);
	localparam int KL    = 2*FB;
	localparam int KC    = 6*FB + 2;
	localparam int CHW   = isi_pkg::CH_W;

	// Catmull-Rom weight of tap k from f, f^2 and f^3
	function automatic logic signed [WW-1:0] cr_w(input logic [1:0] k,
		input logic [FB-1:0] f, input logic [2*FB-1:0] f2, input logic [3*FB-1:0] f3);
		logic signed [WW-1:0] e3, e2s, e1s2, es3, w;
		e3   = $signed(WW'(f3));
		e2s  = $signed(WW'(f2) << FB);
		e1s2 = $signed(WW'(f) << (2*FB));
		es3  = $signed(WW'(1) << (3*FB));
		unique case (k)
			2'd0:    w = -e3 + WW'(2)*e2s - e1s2;
			2'd1:    w = WW'(3)*e3 - WW'(5)*e2s + WW'(2)*es3;
			2'd2:    w = -(WW'(3)*e3) + WW'(4)*e2s + e1s2;
			default: w = e3 - e2s;
		endcase
		return w;
	endfunction

	// Nearest integer, half away from zero
	function automatic logic signed [CW-1:0] round_coord(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] h, r;
		h = CW'(1) << (FB - 1);
		if (v[CW-1]) begin
			r = -((-v + h) >>> FB);
		end else begin
			r = (v + h) >>> FB;
		end
		return r;
	endfunction

	logic [32-1:0]              mem [DEPTH];
	logic signed [CW-1:0]       x_q, y_q;
	logic [2*FB-1:0]            fx2_q, fy2_q;
	logic [3*FB-1:0]            fx3_q, fy3_q;
	logic signed [WW-1:0]       wx_q [4];
	logic signed [WW-1:0]       wy_q [4];
	logic signed [CW-1:0]       base_col_q, base_row_q;
	logic [FB-1:0]              fx, fy;

	logic [CW-1:0]              wlim, hlim, tcol, trow, wcol, wrow;
	logic                       tap_in, wr_ok;
	logic [ADW-1:0]             addr;

	logic [32-1:0]              rd_s1;
	logic                       inb_s1, v_s1, v_s2, v_s3;
	logic [1:0]                 i_s1, j_s1;
	logic signed [PW-1:0]       p_s2 [4];
	logic signed [LW:0]         wyl_s2;
	logic signed [HW-1:0]       wyh_s2;
	logic signed [MLW-1:0]      ml_s3 [4];
	logic signed [MHW-1:0]      mh_s3 [4];
	logic signed [AW-1:0]       acc_q [4];
	logic [4*CHW-1:0]           out_q;

	assign fx = x_q[FB-1:0];
	assign fy = y_q[FB-1:0];

	// Clip the configured size to the store
	assign wlim = (CW'(image_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(image_width);
	assign hlim = (CW'(image_height) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(image_height);

	// Tap position and bounds check
	assign tcol   = base_col_q + CW'(cmd.tap_i);
	assign trow   = base_row_q + CW'(cmd.tap_j);
	assign tap_in = !tcol[CW-1] && !trow[CW-1] && (tcol < wlim) && (trow < hlim);
	assign wcol   = CW'(write_col);
	assign wrow   = CW'(write_row);
	assign wr_ok  = (wcol < CW'(MAX_WIDTH)) && (wrow < CW'(MAX_HEIGHT));

	// Share one memory port between writes and tap reads
	always_comb begin
		if (cmd.write) begin
			addr = ADW'(wrow[RB-1:0]) * ADW'(MAX_WIDTH) + ADW'(wcol[CB-1:0]);
		end else begin
			addr = ADW'(trow[RB-1:0]) * ADW'(MAX_WIDTH) + ADW'(tcol[CB-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && wr_ok) begin
			mem[addr] <= write_pixel;
		end
		rd_s1 <= mem[addr];
	end

	// Coordinate, powers of the fraction and weights
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= CW'(sample_x);
			y_q <= CW'(sample_y);
		end
		if (cmd.square) begin
			fx2_q <= fx * fx;
			fy2_q <= fy * fy;
		end
		if (cmd.cube) begin
			fx3_q <= fx2_q * (2*FB)'(fx);
			fy3_q <= fy2_q * (2*FB)'(fy);
		end
		if (cmd.weight) begin
			for (int k = 0; k < 4; k++) begin
				unique case (method)
					isi_pkg::METH_NEAREST: begin
						wx_q[k] <= (k == 1) ? WW'(1) : '0;
						wy_q[k] <= (k == 1) ? WW'(1) : '0;
					end
					isi_pkg::METH_BILINEAR: begin
						wx_q[k] <= (k == 1) ? (WW'(1) << FB) - WW'(fx) :
							(k == 2) ? WW'(fx) : '0;
						wy_q[k] <= (k == 1) ? (WW'(1) << FB) - WW'(fy) :
							(k == 2) ? WW'(fy) : '0;
					end
					isi_pkg::METH_BICUBIC: begin
						wx_q[k] <= cr_w(2'(k), fx, fx2_q, fx3_q);
						wy_q[k] <= cr_w(2'(k), fy, fy2_q, fy3_q);
					end
					default: begin
						wx_q[k] <= '0;
						wy_q[k] <= '0;
					end
				endcase
			end
			if (method == isi_pkg::METH_NEAREST) begin
				base_col_q <= round_coord(x_q) - CW'(1);
				base_row_q <= round_coord(y_q) - CW'(1);
			end else begin
				base_col_q <= (x_q >>> FB) - CW'(1);
				base_row_q <= (y_q >>> FB) - CW'(1);
			end
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.tap_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign stat.busy = v_s1 || v_s2 || v_s3;

	// Multiply-accumulate lanes, one per channel
	always_ff @(posedge clk) begin
		inb_s1 <= tap_in;
		i_s1   <= cmd.tap_i;
		j_s1   <= cmd.tap_j;
		wyl_s2 <= $signed({1'b0, wy_q[j_s1][LW-1:0]});
		wyh_s2 <= wy_q[j_s1][WW-1:LW];
		for (int c = 0; c < 4; c++) begin
			p_s2[c]  <= $signed({1'b0, (inb_s1 ? rd_s1[c*CHW +: CHW] : {CHW{1'b0}})})
				* wx_q[i_s1];
			ml_s3[c] <= p_s2[c] * wyl_s2;
			mh_s3[c] <= p_s2[c] * wyh_s2;
			if (cmd.load) begin
				acc_q[c] <= '0;
			end else if (v_s3) begin
				acc_q[c] <= acc_q[c] + AW'(ml_s3[c]) + (AW'(mh_s3[c]) <<< LW);
			end
		end
	end

	// Round half up for bilinear and bicubic, drop negatives, clamp to the channel range
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			for (int c = 0; c < 4; c++) begin
				logic [AW-1:0] a, r;
				a = acc_q[c];
				unique case (method)
					isi_pkg::METH_BILINEAR: r = (a + (AW'(1) << (KL - 1))) >> KL;
					isi_pkg::METH_BICUBIC:  r = (a + (AW'(1) << (KC - 1))) >> KC;
					default:                r = a;
				endcase
				if (a[AW-1]) begin
					out_q[c*CHW +: CHW] <= '0;
				end else if (r > AW'(255)) begin
					out_q[c*CHW +: CHW] <= {CHW{1'b1}};
				end else begin
					out_q[c*CHW +: CHW] <= r[CHW-1:0];
				end
			end
		end
	end

	assign result = out_q;

endmodule

FILE: test/testbench.sv
// Testbench of the image sample interpolator: random pixel writes and samples checked against a predictor.
module testbench;

	localparam int LIMIT = 1500000;
	localparam int DRAIN = 40;
	// Side of the written square in the top left corner used by random phases
	localparam int FILL  = 16;
	localparam logic [1:0] METH_RESERVED = 2'd3;

	typedef struct {
		logic                               action;
		logic [isi_pkg::POS_W-1:0]          col;
		logic [isi_pkg::POS_W-1:0]          row;
		logic [isi_pkg::CH_W-1:0]           ch[4];
		logic signed [isi_pkg::COORD_W-1:0] x;
		logic signed [isi_pkg::COORD_W-1:0] y;
	} in_word_t;

	typedef struct {
		logic [isi_pkg::CH_W-1:0] ch[4];
	} rgba_t;

	// Image store copy, configuration and pending samples
	class sample_board;
		logic [31:0] pixels[16384];
		logic [7:0]  img_w;
		logic [7:0]  img_h;
		logic [1:0]  meth;
		rgba_t       pending[$];
		int          fails;

		function new();
			img_w = 8'd128;
			img_h = 8'd128;
			meth  = isi_pkg::METH_BILINEAR;
			fails = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			if (idx == isi_pkg::CFG_WIDTH) img_w = val;
			else if (idx == isi_pkg::CFG_HEIGHT) img_h = val;
			else if (idx == isi_pkg::CFG_METHOD) meth = val[1:0];
		endfunction

		function longint pix(longint c, longint r, int k);
			longint w;
			longint h;
			w = img_w > 128 ? 128 : img_w;
			h = img_h > 128 ? 128 : img_h;
			if (c < 0 || c >= w || r < 0 || r >= h) return 0;
			return longint'(pixels[r * 128 + c][8*k +: 8]);
		endfunction

		function void cr_taps(longint f, output longint w[4]);
			longint f2s;
			longint f3;
			longint fs2;
			f2s = f * f * 256;
			f3  = f * f * f;
			fs2 = f * 65536;
			w[0] = -f3 + 2 * f2s - fs2;
			w[1] = 3 * f3 - 5 * f2s + 2 * 256 * 65536;
			w[2] = -3 * f3 + 4 * f2s + fs2;
			w[3] = f3 - f2s;
		endfunction

		// Predict one word: update the store or queue the expected pixel
		function void note_input(in_word_t wd);
			longint x, y, fx, fy, ix, iy, rx, ry, s, v;
			longint wx[4];
			longint wy[4];
			logic signed [127:0] acc, rs, wv;
			rgba_t e;
			if (wd.action == isi_pkg::ACT_WRITE) begin
				pixels[wd.row * 128 + wd.col] = {wd.ch[3], wd.ch[2], wd.ch[1], wd.ch[0]};
				return;
			end
			x = longint'(wd.x);
			y = longint'(wd.y);
			fx = x & 255;
			fy = y & 255;
			ix = x >>> 8;
			iy = y >>> 8;
			cr_taps(fx, wx);
			cr_taps(fy, wy);
			for (int k = 0; k < 4; k++) begin
				v = 0;
				if (meth == isi_pkg::METH_NEAREST) begin
					rx = x >= 0 ? (x + 128) / 256 : -((-x + 128) / 256);
					ry = y >= 0 ? (y + 128) / 256 : -((-y + 128) / 256);
					v = pix(rx, ry, k);
				end else if (meth == isi_pkg::METH_BILINEAR) begin
					v = pix(ix, iy, k) * (256 - fx) * (256 - fy)
						+ pix(ix + 1, iy, k) * fx * (256 - fy)
						+ pix(ix, iy + 1, k) * (256 - fx) * fy
						+ pix(ix + 1, iy + 1, k) * fx * fy;
					v = (v + 32768) >> 16;
				end else if (meth == isi_pkg::METH_BICUBIC) begin
					acc = 0;
					for (int j = 0; j < 4; j++) begin
						s = 0;
						for (int i = 0; i < 4; i++)
							s += pix(ix - 1 + i, iy - 1 + j, k) * wx[i];
						rs = 128'(s);
						wv = 128'(wy[j]);
						acc += rs * wv;
					end
					if (acc < 0) v = 0;
					else begin
						acc = (acc + (128'sd1 <<< 49)) >>> 50;
						v = acc > 255 ? 255 : longint'(acc);
					end
				end
				e.ch[k] = v > 255 ? 8'd255 : v[7:0];
			end
			pending.push_back(e);
		endfunction

		// Compare one result with the oldest expected pixel
		function void check_result(rgba_t got);
			rgba_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got.ch);
				fails++;
				return;
			end
			e = pending.pop_front();
			for (int k = 0; k < 4; k++)
				if (got.ch[k] !== e.ch[k]) begin
					$display("%0t: channel %0d expected %0d actual %0d", $time, k,
						e.ch[k], got.ch[k]);
					fails++;
				end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [isi_pkg::CFG_W-1:0] cfg_data;
	int idle_pct;
	int stall_pct;
	int cycles;
	sample_board board;

	isi_in_if din_if();
	isi_out_if dout_if();

	image_sample_interpolator dut (
		.clk(clk), .arst_n(arst_n), .din(din_if), .dout(dout_if),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Stall the result side at random
	always @(negedge clk) begin
		dout_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watch both channels at the rising edge
	always @(posedge clk) begin
		in_word_t w;
		rgba_t r;
		if (arst_n && din_if.valid && din_if.ready) begin
			w.action = din_if.action;
			w.col = din_if.write_col;
			w.row = din_if.write_row;
			w.ch[0] = din_if.write_red;
			w.ch[1] = din_if.write_green;
			w.ch[2] = din_if.write_blue;
			w.ch[3] = din_if.write_alpha;
			w.x = din_if.sample_x;
			w.y = din_if.sample_y;
			board.note_input(w);
		end
		if (arst_n && dout_if.valid && dout_if.ready) begin
			r.ch[0] = dout_if.out_red;
			r.ch[1] = dout_if.out_green;
			r.ch[2] = dout_if.out_blue;
			r.ch[3] = dout_if.out_alpha;
			board.check_result(r);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Drive one word; called at a falling edge, returns at a falling edge
	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			din_if.valid = 1'b0;
			@(negedge clk);
		end
		din_if.valid = 1'b1;
		din_if.action = w.action;
		din_if.write_col = w.col;
		din_if.write_row = w.row;
		din_if.write_red = w.ch[0];
		din_if.write_green = w.ch[1];
		din_if.write_blue = w.ch[2];
		din_if.write_alpha = w.ch[3];
		din_if.sample_x = w.x;
		din_if.sample_y = w.y;
		do @(posedge clk); while (!din_if.ready);
		@(negedge clk);
	endtask

	task automatic write_pixel(int c, int r);
		in_word_t w;
		w.action = isi_pkg::ACT_WRITE;
		w.col = isi_pkg::POS_W'(c);
		w.row = isi_pkg::POS_W'(r);
		for (int k = 0; k < 4; k++) w.ch[k] = isi_pkg::CH_W'($urandom());
		w.x = isi_pkg::COORD_W'($urandom());
		w.y = isi_pkg::COORD_W'($urandom());
		send_word(w);
	endtask

	task automatic sample_at(int x, int y);
		in_word_t w;
		w.action = isi_pkg::ACT_SAMPLE;
		w.col = isi_pkg::POS_W'($urandom());
		w.row = isi_pkg::POS_W'($urandom());
		for (int k = 0; k < 4; k++) w.ch[k] = isi_pkg::CH_W'($urandom());
		w.x = isi_pkg::COORD_W'(x);
		w.y = isi_pkg::COORD_W'(y);
		send_word(w);
	endtask

	// Hold until all results are in and the block has gone quiet
	task automatic settle();
		din_if.valid = 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [7:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic setup(logic [7:0] w, logic [7:0] h, logic [1:0] m);
		settle();
		set_reg(isi_pkg::CFG_WIDTH, w);
		set_reg(isi_pkg::CFG_HEIGHT, h);
		set_reg(isi_pkg::CFG_METHOD, m);
	endtask

	task automatic random_items(int n);
		int span_w;
		int span_h;
		span_w = board.img_w > 128 ? 128 : board.img_w;
		span_h = board.img_h > 128 ? 128 : board.img_h;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 25) write_pixel($urandom_range(127), $urandom_range(127));
			else if ($urandom_range(99) < 15) sample_at($urandom(), $urandom());
			else sample_at($urandom_range((span_w + 2) * 256) - 512,
				$urandom_range((span_h + 2) * 256) - 512);
			// at the midpoint, sometimes pause once until the result queue runs dry
			if (i == n / 2 && $urandom_range(3) == 0) begin
				din_if.valid = 1'b0;
				while (board.pending.size() != 0) @(negedge clk);
			end
		end
	endtask

	initial begin
		logic [7:0] w;
		logic [7:0] h;
		board = new();
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = isi_pkg::CFG_WIDTH;
		cfg_data = '0;
		din_if.valid = 1'b0;
		din_if.action = isi_pkg::ACT_WRITE;
		din_if.write_col = '0;
		din_if.write_row = '0;
		din_if.write_red = '0;
		din_if.write_green = '0;
		din_if.write_blue = '0;
		din_if.write_alpha = '0;
		din_if.sample_x = '0;
		din_if.sample_y = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill the top left square and the pixels the far-edge samples reach
		for (int r = 0; r < FILL; r++)
			for (int c = 0; c < FILL; c++)
				write_pixel(c, r);
		for (int r = 0; r < 3; r++)
			for (int c = 126; c < 128; c++)
				write_pixel(c, r);
		for (int r = 126; r < 128; r++)
			for (int c = 126; c < 128; c++)
				write_pixel(c, r);

		// Directed corners, halves and extremes under the reset setting, then under every method code and edge sizes
		sample_at(0, 0);
		sample_at(32767, 32767);
		sample_at(128, 255);
		sample_at(-65536, 65535);
		for (int m = 0; m < 4; m++) begin
			setup(8'd128, 8'd128, m[1:0]);
			sample_at(128, 128);
			sample_at(-128, -129);
			sample_at(32767, 0);
			sample_at(32640, 32640);
			sample_at(65535, -65536);
		end
		setup(8'd0, 8'd5, isi_pkg::METH_BILINEAR);
		sample_at(256, 256);
		setup(8'd255, 8'd255, isi_pkg::METH_BICUBIC);
		sample_at(32700, 32700);
		setup(8'd1, 8'd1, isi_pkg::METH_NEAREST);
		sample_at(0, 127);
		write_pixel(127, 127);

		// Random phases with every idling mix and several settings
		for (int p = 0; p < 4; p++) begin
			for (int m = 0; m < 3; m++) begin
				case ($urandom_range(5))
					0: begin w = 8'd1; h = 8'($urandom_range(1, FILL)); end
					1: begin w = 8'(FILL); h = 8'(FILL); end
					2: begin w = 8'($urandom_range(1, FILL)); h = 8'd1; end
					default: begin
						w = 8'($urandom_range(1, FILL));
						h = 8'($urandom_range(1, FILL));
					end
				endcase
				setup(w, h, ($urandom_range(15) == 0) ? METH_RESERVED : m[1:0]);
				idle_pct = (p == 1) ? 85 : (p == 3) ? 19 : 0;
				stall_pct = (p == 2) ? 85 : (p == 3) ? 19 : 0;
				random_items(63);
			end
		end

		settle();
		if (board.fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

FILE: sim.f
rtl/isi_pkg.sv
rtl/isi_in_if.sv
rtl/isi_out_if.sv
rtl/isi_ctrl.sv
rtl/isi_datapath.sv
rtl/image_sample_interpolator.sv
test/testbench.sv
